### hdl/actc_pkg.sv
// ---------------------------------------------------------------------------
// actc_pkg
// Shared types, constants and functions for the counter-mode cipher block:
// s-box table, round constants, register indexes and the job word.
// ---------------------------------------------------------------------------
package actc_pkg;

   localparam int KEY_W   = 128;
   localparam int HALF_W  = 64;
   localparam int LANE_W  = 32;
   localparam int CSR_IDX_W = 3;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_HIGH      = 3'd0,
      REG_KEY_LOW       = 3'd1,
      REG_NONCE_HIGH    = 3'd2,
      REG_NONCE_MID     = 3'd3,
      REG_COUNTER_START = 3'd4,
      REG_CIPHER_MODE   = 3'd5
   } reg_idx_type;

   localparam logic MODE_XOR = 1'b0;
   localparam logic KIND_BLOCK = 1'b0;
   localparam logic KIND_SUM   = 1'b1;

   // one classified job handed from front to back
   typedef struct packed {
      logic [KEY_W-1:0]  ctr_block;
      logic [HALF_W-1:0] data_high;
      logic [HALF_W-1:0] data_low;
      logic              xor_mode;
      logic              emit_sum;
   } job_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ROUND = 2'd1,
      ST_EMIT  = 2'd2,
      ST_SUMS  = 2'd3
   } back_state_type;

   // key expansion sequencer states
   typedef enum logic [0:0] {
      KS_IDLE = 1'b0,
      KS_RUN  = 1'b1
   } ks_state_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      unique case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
         8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
         8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
         8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
         8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
         8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
         8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
         8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
         8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
         8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
         8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
         8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
         8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
         8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
         8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
         8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
         8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
         8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
         8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
         8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
         8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
         8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
         8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
         8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
         8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
         8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
         8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
         8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
         8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
         8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
         8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
         8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
         8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
         8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
         8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
         8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
         8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
         8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
         8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
         8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
         8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
         8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
         8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
         8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
         8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
         8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
         8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
         8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
         8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
         8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
         8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
         8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
         8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // round constant for expansion step r (1..10)
   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] c;
      unique case (r)
         4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
         4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
         4'd9: c = 8'h1B; 4'd10: c = 8'h36;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   // byte i of a 128-bit state, byte 0 in the top bits
   function automatic logic [7:0] sbyte(input logic [KEY_W-1:0] s, input int i);
      return s[KEY_W-1-8*i -: 8];
   endfunction

   // next round key from the previous one
   function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k,
                                                 input logic [3:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]),
            sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // sub bytes, shift rows and optionally mix columns
   function automatic logic [KEY_W-1:0] aes_round(input logic [KEY_W-1:0] s,
                                                  input logic do_mix);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [KEY_W-1:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r+4*c] = sbox(sbyte(s, r + 4*((c+r)&3)));
         end
      end
      if (do_mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         o[KEY_W-1-8*i -: 8] = t[i];
      end
      return o;
   endfunction

   // little-endian 32-bit word w of a 128-bit block
   function automatic logic [LANE_W-1:0] le_word(input logic [KEY_W-1:0] b,
                                                 input int w);
      return {sbyte(b, 4*w+3), sbyte(b, 4*w+2), sbyte(b, 4*w+1), sbyte(b, 4*w)};
   endfunction

endpackage

### hdl/actc_ram.sv
// ---------------------------------------------------------------------------
// actc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module actc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### hdl/actc_front.sv
// ---------------------------------------------------------------------------
// actc_front
// Accepts blocks, builds the counter block, keeps the counter and queues
// jobs for the cipher engine in a short queue.
// ---------------------------------------------------------------------------
module actc_front #(
   parameter int QDEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [63:0]                   req_data_high,
   input  logic [63:0]                   req_data_low,
   input  logic                          req_last_block,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [63:0]                   csr_wdata,
   input  logic                          hold,
   output logic                          job_valid,
   output actc_pkg::job_type             job,
   input  logic                          job_take
);
   import actc_pkg::*;

   localparam int PW = $clog2(QDEPTH);

   logic [63:0] nonce_high_ff;
   logic [31:0] nonce_mid_ff, counter_start_ff, counter_ff, counter_in;
   logic        mode_ff;
   job_type     q_ff [QDEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [PW:0] cnt_ff;
   logic        accept;
   job_type     new_job;

   assign req_full  = (cnt_ff == (PW+1)'(QDEPTH)) || hold;
   assign accept    = req_push && !req_full;
   assign job_valid = cnt_ff != '0;
   assign job       = q_ff[rp_ff];

   // classify the incoming word
   always_comb begin
      new_job.ctr_block = {nonce_high_ff, nonce_mid_ff, counter_ff};
      new_job.data_high = req_data_high;
      new_job.data_low  = req_data_low;
      new_job.xor_mode  = mode_ff == MODE_XOR;
      new_job.emit_sum  = req_last_block;
   end

   // counter advance, restart on the last block, load on a counter-start write
   always_comb begin
      counter_in = counter_ff;
      if (accept) begin
         counter_in = req_last_block ? counter_start_ff : counter_ff + 32'd1;
      end
      if (csr_we && csr_index == REG_COUNTER_START) begin
         counter_in = csr_wdata[31:0];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nonce_high_ff    <= '0;
         nonce_mid_ff     <= '0;
         counter_start_ff <= '0;
         mode_ff          <= MODE_XOR;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_NONCE_HIGH:    nonce_high_ff    <= csr_wdata;
            REG_NONCE_MID:     nonce_mid_ff     <= csr_wdata[31:0];
            REG_COUNTER_START: counter_start_ff <= csr_wdata[31:0];
            REG_CIPHER_MODE:   mode_ff          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // counter and job queue
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         wp_ff      <= '0;
         rp_ff      <= '0;
         cnt_ff     <= '0;
      end else begin
         counter_ff <= counter_in;
         if (accept) begin
            wp_ff <= (wp_ff == PW'(QDEPTH-1)) ? '0 : wp_ff + 1'b1;
         end
         if (job_take) begin
            rp_ff <= (rp_ff == PW'(QDEPTH-1)) ? '0 : rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (PW+1)'(accept) - (PW+1)'(job_take);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wp_ff] <= new_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(QDEPTH)) else $error("job queue overflow");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid) else $error("take from empty job queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      accept && !job_take |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("job count did not advance");
endmodule

### hdl/actc_keysched.sv
// ---------------------------------------------------------------------------
// actc_keysched
// Expands the key into the round key memory, one round key per cycle,
// rerun after reset and after every key write.
// ---------------------------------------------------------------------------
module actc_keysched (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic [3:0]  rk_rd_addr,
   output logic [127:0] rk_rd_data,
   output logic        busy
);
   import actc_pkg::*;

   localparam int RKN = 11;
   localparam int AW  = $clog2(RKN);

   ks_state_type  state_ff, state_in;
   logic [63:0]   key_high_ff, key_low_ff;
   logic [127:0]  cur_ff, cur_in;
   logic [AW-1:0] step_ff, step_in;
   logic          key_write, wr_en;

   assign key_write = csr_we && (csr_index == REG_KEY_HIGH || csr_index == REG_KEY_LOW);
   assign busy      = state_ff == KS_RUN || key_write;
   assign wr_en     = state_ff == KS_RUN;

   // two 64-bit halves of each round key in one 128-bit word
   actc_ram #(.WIDTH(128), .DEPTH(RKN)) u_rk (
      .clock(clock), .wr_en(wr_en), .wr_addr(step_ff), .wr_data(cur_ff),
      .rd_addr(rk_rd_addr), .rd_data(rk_rd_data));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         KS_IDLE: if (key_write) state_in = KS_RUN;
         KS_RUN:  if (step_ff == AW'(RKN-1) && !key_write) state_in = KS_IDLE;
         default: state_in = KS_IDLE;
      endcase
   end

   // step and working key
   always_comb begin
      step_in = step_ff + 1'b1;
      cur_in  = next_key(cur_ff, 4'(step_ff + 1'b1));
      if (key_write || state_ff == KS_IDLE) begin
         step_in = '0;
         cur_in  = {key_write && csr_index == REG_KEY_HIGH ? csr_wdata : key_high_ff,
                    key_write && csr_index == REG_KEY_LOW  ? csr_wdata : key_low_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= KS_RUN;
         step_ff     <= '0;
         key_high_ff <= '0;
         key_low_ff  <= '0;
         cur_ff      <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cur_ff   <= cur_in;
         if (key_write && csr_index == REG_KEY_HIGH) key_high_ff <= csr_wdata;
         if (key_write && csr_index == REG_KEY_LOW)  key_low_ff  <= csr_wdata;
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == KS_RUN |-> step_ff <= AW'(RKN-1)) else $error("key step out of range");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      key_write |=> state_ff == KS_RUN && step_ff == '0) else $error("no rerun on key write");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == KS_RUN |-> busy) else $error("busy low while expanding");
endmodule

### hdl/actc_back.sv
// ---------------------------------------------------------------------------
// actc_back
// Runs one round per cycle on a shared round unit, applies the data,
// updates the checksum lanes and drives a two-entry result queue.
// ---------------------------------------------------------------------------
module actc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  actc_pkg::job_type job,
   output logic              job_take,
   output logic [3:0]        rk_rd_addr,
   input  logic [127:0]      rk_rd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [63:0]       rsp_result_high,
   output logic [63:0]       rsp_result_low,
   output logic              rsp_result_kind,
   output logic              rsp_result_last
);
   import actc_pkg::*;

   localparam int LANES = 8;
   localparam int OQ    = 2;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
      logic        kind;
      logic        last;
   } res_type;

   back_state_type state_ff, state_in;
   job_type        cur_ff;
   logic [127:0]   st_ff, st_in;
   logic [3:0]     rnd_ff, rnd_in;
   logic [1:0]     sum_ff;
   logic [LANE_W-1:0] lane_ff [LANES];
   logic [127:0]   pend_ff;
   logic           phase_ff;
   res_type        oq_ff [OQ];
   logic           ow_ff, or_ff;
   logic [1:0]     ocnt_ff;
   logic           opush, opop, oroom;
   res_type        ores;
   logic [127:0]   ks_blk, din;

   assign oroom     = ocnt_ff != 2'd2;
   assign opop      = rsp_pop && !rsp_empty;
   assign rsp_empty = ocnt_ff == 2'd0;
   assign {rsp_result_high, rsp_result_low, rsp_result_kind, rsp_result_last} = oq_ff[or_ff];
   assign job_take  = state_ff == ST_IDLE && job_valid;
   assign din       = {cur_ff.data_high, cur_ff.data_low};
   assign ks_blk    = st_ff ^ (cur_ff.xor_mode ? din : '0);

   // round key fetch runs one ahead of the round counter
   assign rk_rd_addr = (state_ff == ST_IDLE) ? 4'd0 : rnd_ff + 4'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 4'd10) state_in = ST_EMIT;
         ST_EMIT:  if (oroom) state_in = (cur_ff.emit_sum && cur_ff.xor_mode) ?
                                         ST_SUMS : ST_IDLE;
         ST_SUMS:  if (oroom && sum_ff == 2'd3) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // round datapath: key add at round 0, then ten rounds
   always_comb begin
      st_in  = st_ff;
      rnd_in = rnd_ff;
      if (state_ff == ST_ROUND) begin
         if (rnd_ff == 4'd0) st_in = cur_ff.ctr_block ^ rk_rd_data;
         else st_in = aes_round(st_ff, rnd_ff != 4'd10) ^ rk_rd_data;
         rnd_in = rnd_ff + 4'd1;
      end else begin
         rnd_in = '0;
      end
   end

   // result selection
   always_comb begin
      opush = 1'b0;
      ores  = '0;
      unique case (state_ff)
         ST_EMIT: begin
            opush = oroom;
            ores  = '{hi: ks_blk[127:64], lo: ks_blk[63:0], kind: KIND_BLOCK,
                      last: !(cur_ff.emit_sum && cur_ff.xor_mode)};
         end
         ST_SUMS: begin
            opush = oroom;
            ores  = '{hi: {32'd0, lane_ff[{sum_ff, 1'b0}]},
                      lo: {32'd0, lane_ff[{sum_ff, 1'b1}]},
                      kind: KIND_SUM, last: sum_ff == 2'd3};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         sum_ff   <= '0;
         phase_ff <= 1'b0;
         ow_ff    <= 1'b0;
         or_ff    <= 1'b0;
         ocnt_ff  <= '0;
         for (int i = 0; i < LANES; i++) lane_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         if (opush) ow_ff <= !ow_ff;
         if (opop)  or_ff <= !or_ff;
         ocnt_ff <= ocnt_ff + 2'(opush) - 2'(opop);
         // checksum update once the block word is out
         if (state_ff == ST_EMIT && oroom) begin
            if (cur_ff.xor_mode) begin
               if (!phase_ff) begin
                  phase_ff <= 1'b1;
               end else begin
                  phase_ff <= 1'b0;
                  for (int w = 0; w < 4; w++) begin
                     lane_ff[w]   <= lane_ff[w]   + le_word(pend_ff, w);
                     lane_ff[w+4] <= lane_ff[w+4] + le_word(din, w);
                  end
               end
            end
            if (cur_ff.emit_sum && !cur_ff.xor_mode) begin
               phase_ff <= 1'b0;
               for (int i = 0; i < LANES; i++) lane_ff[i] <= '0;
            end
         end
         if (state_ff == ST_SUMS && oroom) begin
            sum_ff <= sum_ff + 2'd1;
            if (sum_ff == 2'd3) begin
               phase_ff <= 1'b0;
               for (int i = 0; i < LANES; i++) lane_ff[i] <= '0;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (job_take) cur_ff <= job;
      st_ff <= st_in;
      if (state_ff == ST_EMIT && oroom && cur_ff.xor_mode && !phase_ff) pend_ff <= din;
      if (opush) oq_ff[ow_ff] <= ores;
   end

   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= 2'd2) else $error("result queue overflow");
   a_round_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && rnd_ff == 4'd10 |=> state_ff == ST_EMIT)
      else $error("round count wrong");
   a_sum_kind: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUMS && opush |-> ores.kind == KIND_SUM) else $error("bad kind");
endmodule

### hdl/aes128_ctr_with_checksum_top.sv
// ---------------------------------------------------------------------------
// aes128_ctr_with_checksum_top
// AES-128 counter mode with an eight-lane word checksum.
// ---------------------------------------------------------------------------
// Each block passes through the engine in order: a queue hand-over, the
// single shared round unit (key add plus ten rounds) and the result
// write; a last block in XOR mode then adds four checksum words. After
// reset and after each key write the key schedule fills the round key
// memory, during which no block is taken. A two-deep job queue lets
// blocks be taken while the engine is busy, and a two-deep result queue
// decouples the output side.
module aes128_ctr_with_checksum_top #(
   parameter int JOB_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   input  logic        req_last_block,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   output logic        rsp_result_kind,
   output logic        rsp_result_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import actc_pkg::*;

   logic         ks_busy, job_valid, job_take;
   job_type      job;
   logic [3:0]   rk_addr;
   logic [127:0] rk_data;

   // key schedule
   actc_keysched u_ks (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .rk_rd_addr(rk_addr), .rk_rd_data(rk_data), .busy(ks_busy));

   // front end
   actc_front #(.QDEPTH(JOB_DEPTH)) u_front (
      .clock, .reset, .req_push, .req_full, .req_data_high, .req_data_low,
      .req_last_block, .csr_we, .csr_index, .csr_wdata, .hold(ks_busy),
      .job_valid, .job, .job_take);

   // cipher engine
   actc_back u_back (
      .clock, .reset, .job_valid(job_valid && !ks_busy), .job, .job_take,
      .rk_rd_addr(rk_addr), .rk_rd_data(rk_data), .rsp_empty, .rsp_pop,
      .rsp_result_high, .rsp_result_low, .rsp_result_kind, .rsp_result_last);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ks_busy |-> req_full) else $error("input open during key expansion");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |-> !ks_busy) else $error("job taken during key expansion");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty) else $error("waiting word dropped");
endmodule

### verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the AES-128 counter-mode block with checksum.
// A queue-fed driver offers blocks with random gaps. An in-bench cipher and
// checksum predictor builds the expected words. A monitor pops results with
// random stalls, plus one long hold-off, and compares each field in order.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import actc_pkg::*;

   localparam logic [2:0] REG_SPARE_A = 3'd6;
   localparam logic [2:0] REG_SPARE_B = 3'd7;
   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 30;

   typedef struct {
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic        last_block;
   } block_word_type;

   typedef struct {
      logic [63:0] high;
      logic [63:0] low;
      logic        kind;
      logic        last;
   } result_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_data_high = '0;
   logic [63:0] req_data_low = '0;
   logic        req_last_block = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        rsp_result_kind;
   logic        rsp_result_last;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   aes128_ctr_with_checksum_top u_top (.*);

   // clock
   always #5 clock = ~clock;

   block_word_type  blocks_to_send[$];
   result_word_type expected_words[$];
   int           mismatches = 0;
   int           results_seen = 0;
   bit           calm = 1'b0;

   // predictor state
   logic [7:0]   sub_byte[256];
   logic [127:0] round_keys[11];
   logic [63:0]  key_hi, key_lo, nonce_hi;
   logic [31:0]  nonce_md, ctr_start, ctr_now;
   logic         mode_now;
   logic [31:0]  lanes[8];
   logic [63:0]  held_hi, held_lo;
   logic         odd_phase;

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
      end
      return p;
   endfunction

   // s-box from field inverse and affine map
   function automatic void build_sub_bytes();
      logic [7:0] inv, s;
      for (int a = 0; a < 256; a++) begin
         inv = 0;
         for (int b = 1; b < 256; b++) begin
            if (gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
         end
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sub_byte[a] = s;
      end
   endfunction

   function automatic logic [7:0] dbl(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   // round key schedule
   function automatic void expand_round_keys();
      logic [31:0] w[44];
      logic [31:0] t;
      logic [7:0]  rc;
      {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {sub_byte[t[23:16]] ^ rc, sub_byte[t[15:8]], sub_byte[t[7:0]],
                 sub_byte[t[31:24]]};
            rc = dbl(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   function automatic logic [127:0] encrypt_block(logic [127:0] blk);
      logic [7:0] st[16], t[16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] s;
      s = blk ^ round_keys[0];
      for (int r = 1; r < 11; r++) begin
         for (int i = 0; i < 16; i++) st[i] = s[127-8*i -: 8];
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) t[w+4*c] = sub_byte[st[w + 4*((c+w)&3)]];
         if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
               t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
               t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
               t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[127-8*i -: 8] = t[i];
         s ^= round_keys[r];
      end
      return s;
   endfunction

   // four little-endian words of a block into lanes base..base+3
   function automatic void add_to_lanes(logic [63:0] hi, logic [63:0] lo, int base);
      logic [127:0] b;
      b = {hi, lo};
      for (int w = 0; w < 4; w++)
         lanes[base+w] += {b[127-8*(4*w+3) -: 8], b[127-8*(4*w+2) -: 8],
                           b[127-8*(4*w+1) -: 8], b[127-8*(4*w) -: 8]};
   endfunction

   function automatic void restart_stream();
      ctr_now = ctr_start;
      foreach (lanes[i]) lanes[i] = 0;
      odd_phase = 0;
   endfunction

   // expected results of one accepted block
   function automatic void predict_block(block_word_type b);
      logic [127:0] ks;
      result_word_type r;
      logic xor_mode;
      xor_mode = (mode_now == MODE_XOR);
      ks = encrypt_block({nonce_hi, nonce_md, ctr_now});
      ctr_now += 1;
      r = '{ks[127:64], ks[63:0], KIND_BLOCK, 1'b1};
      if (xor_mode) begin
         r.high ^= b.data_high;
         r.low ^= b.data_low;
         if (!odd_phase) begin
            held_hi = b.data_high;
            held_lo = b.data_low;
            odd_phase = 1;
         end else begin
            add_to_lanes(held_hi, held_lo, 0);
            add_to_lanes(b.data_high, b.data_low, 4);
            odd_phase = 0;
         end
      end
      if (b.last_block && xor_mode) r.last = 0;
      expected_words.push_back(r);
      if (b.last_block) begin
         if (xor_mode) begin
            for (int j = 0; j < 4; j++)
               expected_words.push_back('{{32'h0, lanes[2*j]}, {32'h0, lanes[2*j+1]},
                                          KIND_SUM, j == 3});
         end
         restart_stream();
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // alternate stretches with and without idling
   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0) calm <= ~calm;
   end

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      logic next_push;
      next_push = 1'b0;
      if (!reset) begin
         if (req_push && !req_full) begin
            predict_block(blocks_to_send.pop_front());
            send_gap = pick_gap();
         end
         if (send_gap > 0) begin
            send_gap--;
         end else if (blocks_to_send.size() > 0) begin
            next_push = 1'b1;
            req_data_high <= blocks_to_send[0].data_high;
            req_data_low <= blocks_to_send[0].data_low;
            req_last_block <= blocks_to_send[0].last_block;
         end
      end
      req_push <= next_push;
   end

   // monitor
   int pop_gap = 0;
   int hold_left = 0;
   bit long_hold_done = 0;
   always @(posedge clock) begin
      result_word_type e;
      logic next_pop;
      next_pop = 1'b0;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: high %h low %h kind %b last %b",
                           rsp_result_high, rsp_result_low, rsp_result_kind,
                           rsp_result_last);
            end else begin
               e = expected_words.pop_front();
               if (e.high !== rsp_result_high || e.low !== rsp_result_low ||
                   e.kind !== rsp_result_kind || e.last !== rsp_result_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h %h %b %b, got %h %h %b %b",
                              e.high, e.low, e.kind, e.last, rsp_result_high,
                              rsp_result_low, rsp_result_kind, rsp_result_last);
               end
            end
            pop_gap = pick_gap();
            // one long hold-off so the block backs up
            if (!long_hold_done && results_seen == 20) begin
               hold_left = 400;
               long_hold_done = 1;
            end
         end
         if (hold_left > 0) hold_left--;
         else if (pop_gap > 0) pop_gap--;
         else next_pop = 1'b1;
      end
      rsp_pop <= next_pop;
   end

   // watchdog on cycles with no accepted word
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_KEY_HIGH: begin key_hi = value; expand_round_keys(); end
         REG_KEY_LOW: begin key_lo = value; expand_round_keys(); end
         REG_NONCE_HIGH: nonce_hi = value;
         REG_NONCE_MID: nonce_md = value[31:0];
         REG_COUNTER_START: begin ctr_start = value[31:0]; ctr_now = value[31:0]; end
         REG_CIPHER_MODE: mode_now = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (blocks_to_send.size() > 0 || expected_words.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_block(logic [63:0] hi, logic [63:0] lo, logic last);
      blocks_to_send.push_back('{hi, lo, last});
   endtask

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int len;
      build_sub_bytes();
      key_hi = 0; key_lo = 0; nonce_hi = 0; nonce_md = 0; ctr_start = 0;
      mode_now = MODE_XOR; held_hi = 0; held_lo = 0;
      expand_round_keys();
      restart_stream();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // defaults: extremes, a pair with last, an unpaired last block
      add_block('0, '0, 0);
      add_block('1, '1, 1);
      add_block('1, '0, 0);
      add_block('0, '1, 0);
      add_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1);
      add_block(64'h8000000000000001, 64'h7FFFFFFFFFFFFFFE, 1);
      drain();

      // all-ones key and nonce, counter wrap, masked writes, spare indexes
      write_reg(REG_KEY_HIGH, '1);
      write_reg(REG_KEY_LOW, '1);
      write_reg(REG_NONCE_HIGH, '1);
      write_reg(REG_NONCE_MID, '1);
      write_reg(REG_COUNTER_START, 64'hFFFF_FFFF_FFFF_FFFE);
      write_reg(REG_CIPHER_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
      write_reg(REG_SPARE_A, '1);
      write_reg(REG_SPARE_B, 64'h5A5A5A5A5A5A5A5A);
      for (int i = 0; i < 4; i++) add_block(rand64(), rand64(), i == 3);
      drain();

      // keystream mode, last block in the middle, then mode change mid pair
      write_reg(REG_CIPHER_MODE, '1);
      add_block('1, '1, 0);
      add_block(64'h1234, 64'h5678, 1);
      add_block('0, '0, 0);
      drain();
      write_reg(REG_CIPHER_MODE, '0);
      add_block(64'hAAAA5555AAAA5555, 64'h5555AAAA5555AAAA, 0);
      drain();
      write_reg(REG_CIPHER_MODE, '1);
      add_block('1, '0, 0);
      drain();
      write_reg(REG_CIPHER_MODE, '0);
      add_block(64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00, 1);
      drain();
      write_reg(REG_KEY_HIGH, '0);
      write_reg(REG_KEY_LOW, '0);
      write_reg(REG_NONCE_HIGH, '0);
      write_reg(REG_NONCE_MID, '0);
      write_reg(REG_COUNTER_START, '0);
      add_block(rand64(), rand64(), 1);
      drain();

      // random phases of streams
      for (int p = 0; p < 6; p++) begin
         if ($urandom_range(0, 1)) write_reg(REG_KEY_HIGH, rand64());
         if ($urandom_range(0, 1)) write_reg(REG_KEY_LOW, rand64());
         if ($urandom_range(0, 1)) write_reg(REG_NONCE_HIGH, rand64());
         if ($urandom_range(0, 1)) write_reg(REG_NONCE_MID, rand64());
         if ($urandom_range(0, 2) == 0)
            write_reg(REG_COUNTER_START, {32'h0, $urandom_range(0, 3) == 0 ?
                                           32'hFFFF_FFFD : $urandom});
         write_reg(REG_CIPHER_MODE, 64'($urandom_range(0, 3) == 0));
         for (int n = 0; n < 15; n += len) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               add_block(rand64(), rand64(), k == len - 1 && $urandom_range(0, 5) != 0);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
